// ===== design/ifr_pkg.sv =====
// ----------------------------------------------------------------------------
// ifr_pkg
// shared types, sizes and codes of the image flip / rotate / invert core
// ----------------------------------------------------------------------------
package ifr_pkg;

   // frame store and image size limits
   localparam int FRAME_BYTES = 262144;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int MAX_DIM     = 4096;
   localparam int POS_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = 13;
   localparam int BPP_W       = 2;
   localparam int MAX_BPP     = 3;
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 3;
   localparam int PROD_W      = 2 * DIM_W;
   localparam int COUNT_W     = $clog2(MAX_DIM * MAX_DIM * MAX_BPP + 1);

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_PX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LEVEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE         = 3'd4;

   // transform codes
   localparam logic [MODE_W-1:0] MODE_INVERT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HMIRROR   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_VMIRROR   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ROT_LEFT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ROT_RIGHT = 3'd4;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // effective configuration, sizes already clamped
   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [BPP_W-1:0]  bpp;
      logic [BYTE_W-1:0] max_level;
      logic [MODE_W-1:0] mode;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRC,
      ST_MUL,
      ST_SCALE,
      ST_MEM,
      ST_RESP
   } state_type;

endpackage

// ===== design/ifr_csr.sv =====
// ----------------------------------------------------------------------------
// ifr_csr
// configuration registers with size clamping
// ----------------------------------------------------------------------------
module ifr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [ifr_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [ifr_pkg::CSR_DATA_W-1:0]  wr_data,
   output ifr_pkg::cfg_type                cfg
);

   logic [ifr_pkg::DIM_W-1:0]  width_ff,  width_in;
   logic [ifr_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [ifr_pkg::BPP_W-1:0]  bpp_ff,    bpp_in;
   logic [ifr_pkg::BYTE_W-1:0] level_ff,  level_in;
   logic [ifr_pkg::MODE_W-1:0] mode_ff,   mode_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      level_in  = level_ff;
      mode_in   = mode_ff;
      if (wr_en) begin
         unique case (wr_index)
            ifr_pkg::REG_IMAGE_WIDTH:  width_in  = wr_data[ifr_pkg::DIM_W-1:0];
            ifr_pkg::REG_IMAGE_HEIGHT: height_in = wr_data[ifr_pkg::DIM_W-1:0];
            ifr_pkg::REG_BYTES_PER_PX: bpp_in    = wr_data[ifr_pkg::BPP_W-1:0];
            ifr_pkg::REG_MAX_LEVEL:    level_in  = wr_data[ifr_pkg::BYTE_W-1:0];
            ifr_pkg::REG_MODE:         mode_in   = wr_data[ifr_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ifr_pkg::DIM_W'(1);
         height_ff <= ifr_pkg::DIM_W'(1);
         bpp_ff    <= ifr_pkg::BPP_W'(1);
         level_ff  <= {ifr_pkg::BYTE_W{1'b1}};
         mode_ff   <= ifr_pkg::MODE_INVERT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         level_ff  <= level_in;
         mode_ff   <= mode_in;
      end
   end

   // clamp sizes to 1..max, zero bytes per pixel acts as one
   always_comb begin
      cfg.width = width_ff;
      if (width_ff == '0) begin
         cfg.width = ifr_pkg::DIM_W'(1);
      end else if (width_ff > ifr_pkg::DIM_W'(ifr_pkg::MAX_DIM)) begin
         cfg.width = ifr_pkg::DIM_W'(ifr_pkg::MAX_DIM);
      end
      cfg.height = height_ff;
      if (height_ff == '0) begin
         cfg.height = ifr_pkg::DIM_W'(1);
      end else if (height_ff > ifr_pkg::DIM_W'(ifr_pkg::MAX_DIM)) begin
         cfg.height = ifr_pkg::DIM_W'(ifr_pkg::MAX_DIM);
      end
      cfg.bpp       = (bpp_ff == '0) ? ifr_pkg::BPP_W'(1) : bpp_ff;
      cfg.max_level = level_ff;
      cfg.mode      = mode_ff;
   end

endmodule

// ===== design/ifr_mul.sv =====
// ----------------------------------------------------------------------------
// ifr_mul
// shared registered multiplier for frame size and row offset
// ----------------------------------------------------------------------------
module ifr_mul (
   input  logic                         clock,
   input  logic [ifr_pkg::DIM_W-1:0]    op_a,
   input  logic [ifr_pkg::DIM_W-1:0]    op_b,
   output logic [ifr_pkg::PROD_W-1:0]   prod
);

   logic [ifr_pkg::PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = ifr_pkg::PROD_W'(op_a) * ifr_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== design/ifr_store.sv =====
// ----------------------------------------------------------------------------
// ifr_store
// frame byte memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ifr_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ifr_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [ifr_pkg::BYTE_W-1:0]    wr_data,
   input  logic [ifr_pkg::ADDR_W-1:0]    rd_addr,
   output logic [ifr_pkg::BYTE_W-1:0]    rd_data
);

   logic [ifr_pkg::BYTE_W-1:0] mem [ifr_pkg::FRAME_BYTES];
   logic [ifr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/image_flip_rotate_invert_core.sv =====
// ----------------------------------------------------------------------------
// image_flip_rotate_invert_core
// frame buffer that loads an image byte by byte and reads it back inverted,
// mirrored or rotated by 90 degrees
// ----------------------------------------------------------------------------
//
// channel   ports                                   handshake
// --------  --------------------------------------  ---------------------------
// request   start, req_func, req_data_byte           start high, busy low
// response  rsp_valid, rsp_out_byte, rsp_last,      one-cycle strobe, no stall
//           rsp_status
// csr       csr_valid, csr_ready, csr_index,        valid and ready high
//           csr_data
//
// a read of a loaded frame keeps busy high through source position, shared
// multiplier, address scaling, registered memory read and response, so no
// new request is taken until it is through; a write passes the multiplier
// and the scaling step, and a read before the frame is loaded keeps busy low
// the response is on the ports in the first cycle with busy low again; for a
// read before load that is the cycle right after the accepting edge
// reset is synchronous and clears control state and configuration; the
// frame memory is not cleared
// the response side cannot stall, so nothing waits on it
// ----------------------------------------------------------------------------
module image_flip_rotate_invert_core (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic [ifr_pkg::BYTE_W-1:0]         req_data_byte,
   // response
   output logic                               rsp_valid,
   output logic [ifr_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_last,
   output logic                               rsp_status,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ifr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ifr_pkg::CSR_DATA_W-1:0]     csr_data
);

   ifr_pkg::cfg_type   cfg;
   ifr_pkg::state_type state_ff, state_in;

   // request capture
   logic                        func_ff, func_in;
   logic [ifr_pkg::BYTE_W-1:0]  data_ff, data_in;

   // frame load state
   logic [ifr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        loaded_ff, loaded_in;

   // read position in the output image
   logic [ifr_pkg::POS_W-1:0]   row_ff, row_in;
   logic [ifr_pkg::POS_W-1:0]   col_ff, col_in;
   logic [ifr_pkg::BPP_W-1:0]   k_ff, k_in;

   // source position and byte address
   logic [ifr_pkg::POS_W-1:0]   sr_ff, sr_in;
   logic [ifr_pkg::POS_W-1:0]   sc_ff, sc_in;
   logic [ifr_pkg::ADDR_W-1:0]  addr_ff, addr_in;

   // response registers
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ifr_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_status_ff, rsp_status_in;

   // control decode
   logic                        accept;
   logic                        mem_we;

   // datapath helpers
   logic                        rot;
   logic [ifr_pkg::DIM_W-1:0]   out_w;
   logic [ifr_pkg::DIM_W-1:0]   out_h;
   logic [ifr_pkg::DIM_W-1:0]   mul_a;
   logic [ifr_pkg::PROD_W-1:0]  prod;
   logic [ifr_pkg::BYTE_W-1:0]  rd_data;
   logic [ifr_pkg::COUNT_W-1:0] size_wh;
   logic [ifr_pkg::COUNT_W-1:0] total;
   logic [ifr_pkg::COUNT_W-1:0] wr_base;
   logic [ifr_pkg::COUNT_W-1:0] wr_next;
   logic [ifr_pkg::ADDR_W-1:0]  pix_addr;
   logic [ifr_pkg::ADDR_W-1:0]  byte_addr;
   logic                        pos_stale;
   logic [ifr_pkg::DIM_W-1:0]   row_inc;
   logic [ifr_pkg::DIM_W-1:0]   col_inc;
   logic [ifr_pkg::BPP_W:0]     k_inc;

   // ---------------------------------------------------------------- units

   ifr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // reads multiply source row by width, writes multiply height by width
   assign mul_a = (func_ff == ifr_pkg::FUNC_READ) ? {1'b0, sr_ff} : cfg.height;

   ifr_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (cfg.width),
      .prod  (prod)
   );

   ifr_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_base[ifr_pkg::ADDR_W-1:0]),
      .wr_data (data_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- geometry

   assign rot   = (cfg.mode == ifr_pkg::MODE_ROT_LEFT) ||
                  (cfg.mode == ifr_pkg::MODE_ROT_RIGHT);
   assign out_w = rot ? cfg.height : cfg.width;
   assign out_h = rot ? cfg.width  : cfg.height;

   // read position left outside the image by a register change
   assign pos_stale = ({1'b0, row_ff} >= out_h) || ({1'b0, col_ff} >= out_w) ||
                      (k_ff >= cfg.bpp);

   assign k_inc   = {1'b0, k_ff} + 1'b1;
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;

   // frame size in bytes, w*h from the multiplier scaled by bytes per pixel
   assign size_wh = ifr_pkg::COUNT_W'(prod);
   always_comb begin
      case (cfg.bpp)
         2'd2:    total = size_wh << 1;
         2'd3:    total = size_wh + (size_wh << 1);
         default: total = size_wh;
      endcase
   end

   // a write after a complete frame restarts the count
   assign wr_base = loaded_ff ? '0 : count_ff;
   assign wr_next = wr_base + 1'b1;

   // byte address of the source pixel, modulo the store size
   assign pix_addr = prod[ifr_pkg::ADDR_W-1:0] + ifr_pkg::ADDR_W'(sc_ff);
   always_comb begin
      case (cfg.bpp)
         2'd2:    byte_addr = pix_addr << 1;
         2'd3:    byte_addr = pix_addr + (pix_addr << 1);
         default: byte_addr = pix_addr;
      endcase
   end

   // ---------------------------------------------------------------- sequencer

   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ifr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == ifr_pkg::FUNC_WRITE) begin
                  state_in = ifr_pkg::ST_MUL;
               end else if (loaded_ff) begin
                  state_in = ifr_pkg::ST_SRC;
               end
            end
         end
         ifr_pkg::ST_SRC: begin
            state_in = ifr_pkg::ST_MUL;
         end
         ifr_pkg::ST_MUL: begin
            state_in = ifr_pkg::ST_SCALE;
         end
         ifr_pkg::ST_SCALE: begin
            state_in = (func_ff == ifr_pkg::FUNC_READ) ? ifr_pkg::ST_MEM : ifr_pkg::ST_IDLE;
         end
         ifr_pkg::ST_MEM: begin
            state_in = ifr_pkg::ST_RESP;
         end
         ifr_pkg::ST_RESP: begin
            state_in = ifr_pkg::ST_IDLE;
         end
         default: begin
            state_in = ifr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy   = 1'b1;
      mem_we = 1'b0;
      unique case (state_ff)
         ifr_pkg::ST_IDLE:  busy   = 1'b0;
         ifr_pkg::ST_SCALE: mem_we = (func_ff == ifr_pkg::FUNC_WRITE);
         default: ;
      endcase
   end

   assign csr_ready = !busy;

   // ---------------------------------------------------------------- datapath

   always_comb begin
      func_in       = func_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      loaded_in     = loaded_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      sr_in         = sr_ff;
      sc_in         = sc_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ifr_pkg::ST_IDLE: begin
            if (accept) begin
               func_in = req_func;
               data_in = req_data_byte;
               if (req_func == ifr_pkg::FUNC_READ) begin
                  if (!loaded_ff) begin
                     // read before load answers at once
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = '0;
                     rsp_last_in   = 1'b0;
                     rsp_status_in = 1'b1;
                  end else if (pos_stale) begin
                     row_in = '0;
                     col_in = '0;
                     k_in   = '0;
                  end
               end
            end
         end

         ifr_pkg::ST_SRC: begin
            sr_in = row_ff;
            sc_in = col_ff;
            case (cfg.mode)
               ifr_pkg::MODE_HMIRROR: begin
                  sc_in = ifr_pkg::POS_W'(cfg.width - {1'b0, col_ff} - 1'b1);
               end
               ifr_pkg::MODE_VMIRROR: begin
                  sr_in = ifr_pkg::POS_W'(cfg.height - {1'b0, row_ff} - 1'b1);
               end
               ifr_pkg::MODE_ROT_LEFT: begin
                  sr_in = col_ff;
                  sc_in = ifr_pkg::POS_W'(cfg.width - {1'b0, row_ff} - 1'b1);
               end
               ifr_pkg::MODE_ROT_RIGHT: begin
                  sr_in = ifr_pkg::POS_W'(cfg.height - {1'b0, col_ff} - 1'b1);
                  sc_in = row_ff;
               end
               default: ;
            endcase
         end

         ifr_pkg::ST_SCALE: begin
            if (func_ff == ifr_pkg::FUNC_WRITE) begin
               count_in      = wr_next;
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b0;
               rsp_status_in = 1'b0;
               if (loaded_ff) begin
                  loaded_in = 1'b0;
                  row_in    = '0;
                  col_in    = '0;
                  k_in      = '0;
               end
               // frame complete
               if (wr_next >= total) begin
                  loaded_in   = 1'b1;
                  rsp_last_in = 1'b1;
                  row_in      = '0;
                  col_in      = '0;
                  k_in        = '0;
               end
            end else begin
               addr_in = byte_addr + ifr_pkg::ADDR_W'(k_ff);
            end
         end

         ifr_pkg::ST_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_last_in   = 1'b0;
            rsp_byte_in   = (cfg.mode == ifr_pkg::MODE_INVERT) ?
                            (cfg.max_level - rd_data) : rd_data;
            // step byte, then column, then row, wrapping after the frame
            k_in = k_inc[ifr_pkg::BPP_W-1:0];
            if (k_inc >= {1'b0, cfg.bpp}) begin
               k_in   = '0;
               col_in = col_inc[ifr_pkg::POS_W-1:0];
               if (col_inc >= out_w) begin
                  col_in = '0;
                  row_in = row_inc[ifr_pkg::POS_W-1:0];
                  if (row_inc >= out_h) begin
                     row_in      = '0;
                     rsp_last_in = 1'b1;
                  end
               end
            end
         end

         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifr_pkg::ST_IDLE;
         count_ff     <= '0;
         loaded_ff    <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         loaded_ff    <= loaded_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      data_ff       <= data_in;
      sr_ff         <= sr_in;
      sc_ff         <= sc_in;
      addr_ff       <= addr_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the image flip / rotate / invert core: drives write
// and read requests in random bursts, reprograms the registers between phases
// and checks every response against a cycle-free prediction of the frame store
// ----------------------------------------------------------------------------
module tb;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_WAIT      = 2000;
   localparam int MAX_PRINTED   = 40;

   // an index the core does not decode
   localparam logic [ifr_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef struct packed {
      logic [ifr_pkg::BYTE_W-1:0] out_byte;
      logic                       last;
      logic                       status;
   } rsp_item_type;

   // ------------------------------------------------------------------------
   // predicted frame store, read position and expected responses
   // ------------------------------------------------------------------------
   class frame_scoreboard;
      logic [ifr_pkg::DIM_W-1:0]  cfg_width;
      logic [ifr_pkg::DIM_W-1:0]  cfg_height;
      logic [ifr_pkg::BPP_W-1:0]  cfg_bpp;
      logic [ifr_pkg::BYTE_W-1:0] cfg_level;
      logic [ifr_pkg::MODE_W-1:0] cfg_mode;

      logic [ifr_pkg::BYTE_W-1:0] frame_mem [ifr_pkg::FRAME_BYTES];
      bit                         mem_written [ifr_pkg::FRAME_BYTES];
      int unsigned                bytes_written;
      bit                         frame_ready;
      int unsigned                row_pos, col_pos, byte_pos;

      rsp_item_type predicted_rsp_q [$];

      int unsigned n_errors, n_checked, n_writes, n_reads, n_early_reads;
      int unsigned n_frames, n_read_wraps;

      function new();
         cfg_width     = ifr_pkg::DIM_W'(1);
         cfg_height    = ifr_pkg::DIM_W'(1);
         cfg_bpp       = ifr_pkg::BPP_W'(1);
         cfg_level     = 8'hff;
         cfg_mode      = ifr_pkg::MODE_INVERT;
         bytes_written = 0;
         frame_ready   = 1'b0;
         restart_read();
      endfunction

      function void restart_read();
         row_pos  = 0;
         col_pos  = 0;
         byte_pos = 0;
      endfunction

      function void set_reg(logic [ifr_pkg::CSR_IDX_W-1:0] idx,
                            logic [ifr_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            ifr_pkg::REG_IMAGE_WIDTH:  cfg_width  = value[ifr_pkg::DIM_W-1:0];
            ifr_pkg::REG_IMAGE_HEIGHT: cfg_height = value[ifr_pkg::DIM_W-1:0];
            ifr_pkg::REG_BYTES_PER_PX: cfg_bpp    = value[ifr_pkg::BPP_W-1:0];
            ifr_pkg::REG_MAX_LEVEL:    cfg_level  = value[ifr_pkg::BYTE_W-1:0];
            ifr_pkg::REG_MODE:         cfg_mode   = value[ifr_pkg::MODE_W-1:0];
            default: ;
         endcase
      endfunction

      // sizes clamped to 1..MAX_DIM, zero bytes per pixel taken as one
      function void frame_dims(output int unsigned w, output int unsigned h,
                               output int unsigned b);
         w = (cfg_width == 0) ? 1 :
             (cfg_width > ifr_pkg::MAX_DIM) ? ifr_pkg::MAX_DIM : cfg_width;
         h = (cfg_height == 0) ? 1 :
             (cfg_height > ifr_pkg::MAX_DIM) ? ifr_pkg::MAX_DIM : cfg_height;
         b = (cfg_bpp == 0) ? 1 : cfg_bpp;
      endfunction

      function int unsigned frame_size();
         int unsigned w, h, b;
         frame_dims(w, h, b);
         return w * h * b;
      endfunction

      // read position as the next read uses it, restarted if out of the image
      function void read_position(output int unsigned r, output int unsigned c,
                                  output int unsigned k, output int unsigned ow,
                                  output int unsigned oh);
         int unsigned w, h, b;
         frame_dims(w, h, b);
         if (cfg_mode == ifr_pkg::MODE_ROT_LEFT || cfg_mode == ifr_pkg::MODE_ROT_RIGHT) begin
            ow = h;
            oh = w;
         end else begin
            ow = w;
            oh = h;
         end
         r = row_pos;
         c = col_pos;
         k = byte_pos;
         if (r >= oh || c >= ow || k >= b) begin
            r = 0;
            c = 0;
            k = 0;
         end
      endfunction

      function int unsigned source_addr(int unsigned r, int unsigned c, int unsigned k);
         int unsigned w, h, b, sr, sc;
         frame_dims(w, h, b);
         sr = r;
         sc = c;
         case (cfg_mode)
            ifr_pkg::MODE_HMIRROR:   sc = w - 1 - c;
            ifr_pkg::MODE_VMIRROR:   sr = h - 1 - r;
            ifr_pkg::MODE_ROT_LEFT:  begin
               sr = c;
               sc = w - 1 - r;
            end
            ifr_pkg::MODE_ROT_RIGHT: begin
               sr = h - 1 - c;
               sc = r;
            end
            default: ;
         endcase
         return ((sr * w + sc) * b + k) % ifr_pkg::FRAME_BYTES;
      endfunction

      // a read of a loaded frame must only touch store bytes written before
      function bit read_is_safe();
         int unsigned r, c, k, ow, oh;
         if (!frame_ready)
            return 1'b1;
         read_position(r, c, k, ow, oh);
         return mem_written[source_addr(r, c, k)];
      endfunction

      function void apply_request(logic func, logic [ifr_pkg::BYTE_W-1:0] data);
         rsp_item_type               want;
         int unsigned                r, c, k, ow, oh, addr;
         logic [ifr_pkg::BYTE_W-1:0] v;
         want = '0;
         if (func == ifr_pkg::FUNC_WRITE) begin
            n_writes++;
            if (frame_ready) begin
               frame_ready   = 1'b0;
               bytes_written = 0;
               restart_read();
            end
            addr = bytes_written % ifr_pkg::FRAME_BYTES;
            frame_mem[addr]   = data;
            mem_written[addr] = 1'b1;
            bytes_written++;
            if (bytes_written >= frame_size()) begin
               frame_ready = 1'b1;
               want.last   = 1'b1;
               restart_read();
               n_frames++;
            end
         end else if (!frame_ready) begin
            want.status = 1'b1;
            n_early_reads++;
         end else begin
            read_position(r, c, k, ow, oh);
            v = frame_mem[source_addr(r, c, k)];
            if (cfg_mode == ifr_pkg::MODE_INVERT)
               v = cfg_level - v;
            want.out_byte = v;
            k++;
            if (k >= ((cfg_bpp == 0) ? 1 : cfg_bpp)) begin
               k = 0;
               c++;
               if (c >= ow) begin
                  c = 0;
                  r++;
                  if (r >= oh) begin
                     r = 0;
                     want.last = 1'b1;
                     n_read_wraps++;
                  end
               end
            end
            row_pos  = r;
            col_pos  = c;
            byte_pos = k;
            n_reads++;
         end
         predicted_rsp_q.push_back(want);
      endfunction

      function int unsigned pending();
         return predicted_rsp_q.size();
      endfunction

      task report_mismatch(string what);
         n_errors++;
         if (n_errors <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_response(logic [ifr_pkg::BYTE_W-1:0] out_byte, logic last, logic status);
         rsp_item_type want;
         if (predicted_rsp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response byte %02h last %0b status %0b",
                                      out_byte, last, status));
            return;
         end
         want = predicted_rsp_q.pop_front();
         n_checked++;
         if (out_byte !== want.out_byte)
            report_mismatch($sformatf("response %0d out_byte %02h, expected %02h",
                                      n_checked, out_byte, want.out_byte));
         if (last !== want.last)
            report_mismatch($sformatf("response %0d last %0b, expected %0b",
                                      n_checked, last, want.last));
         if (status !== want.status)
            report_mismatch($sformatf("response %0d status %0b, expected %0b",
                                      n_checked, status, want.status));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and the core
   // ------------------------------------------------------------------------
   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_func;
   logic [ifr_pkg::BYTE_W-1:0]     req_data_byte;
   logic                           rsp_valid;
   logic [ifr_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                           rsp_last;
   logic                           rsp_status;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [ifr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ifr_pkg::CSR_DATA_W-1:0] csr_data;

   always #HALF_PERIOD clock = ~clock;

   image_flip_rotate_invert_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   frame_scoreboard                sb;
   logic [ifr_pkg::CSR_DATA_W-1:0] reg_val [8];     // values to program, by register code
   int unsigned                    burst_left = 0;  // requests left in the current burst
   int unsigned                    n_items = 0;
   int unsigned                    n_csr_writes = 0;
   int unsigned                    n_phases = 0;
   int unsigned                    cycle_count = 0;

   // ------------------------------------------------------------------------
   // response monitor: a strobe is taken at the edge that ends its cycle
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_out_byte, rsp_last, rsp_status);
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.pending());
      $display("image_flip_rotate_invert_core test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // data bytes lean on the extremes now and then
   function automatic logic [ifr_pkg::BYTE_W-1:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return ifr_pkg::BYTE_W'($urandom);
   endfunction

   // small sizes keep frames short; zero checks the clamp
   function automatic logic [ifr_pkg::CSR_DATA_W-1:0] pick_small_dim();
      if ($urandom_range(0, 9) == 0)
         return '0;
      return ifr_pkg::CSR_DATA_W'($urandom_range(1, 6));
   endfunction

   // mostly defined transforms, sometimes an undefined code (pass through)
   function automatic logic [ifr_pkg::CSR_DATA_W-1:0] pick_mode();
      if ($urandom_range(0, 5) == 0)
         return ifr_pkg::CSR_DATA_W'($urandom_range(ifr_pkg::MODE_ROT_RIGHT + 1,
                                                    2**ifr_pkg::MODE_W - 1));
      return ifr_pkg::CSR_DATA_W'($urandom_range(ifr_pkg::MODE_INVERT,
                                                 ifr_pkg::MODE_ROT_RIGHT));
   endfunction

   // one request: raised at an edge, accepted at the first edge with busy low
   task automatic send_request(input logic func, input logic [ifr_pkg::BYTE_W-1:0] data);
      start         <= 1'b1;
      req_func      <= func;
      req_data_byte <= data;
      do @(posedge clock); while (busy);
      sb.apply_request(func, data);
      n_items++;
      // bursts of random length; start stays high inside a burst
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // a read that would touch a never written store byte turns into a write
   task automatic send_read();
      if (sb.read_is_safe())
         send_request(ifr_pkg::FUNC_READ, ifr_pkg::BYTE_W'($urandom));
      else
         send_request(ifr_pkg::FUNC_WRITE, pick_byte());
   endtask

   // drop start and let every outstanding response come back
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all five registers back to back, valid held across the writes
   task automatic program_regs();
      logic [ifr_pkg::CSR_DATA_W-1:0] value;
      int                             keep_bits;
      csr_valid <= 1'b1;
      for (int idx = ifr_pkg::REG_IMAGE_WIDTH; idx <= ifr_pkg::REG_MODE; idx++) begin
         value = reg_val[idx];
         keep_bits = (idx == ifr_pkg::REG_BYTES_PER_PX) ? ifr_pkg::BPP_W :
                     (idx == ifr_pkg::REG_MAX_LEVEL)    ? ifr_pkg::BYTE_W :
                     (idx == ifr_pkg::REG_MODE)         ? ifr_pkg::MODE_W : ifr_pkg::DIM_W;
         // narrow registers drop the upper data bits; fill them at times
         if (keep_bits < ifr_pkg::DIM_W && $urandom_range(0, 7) == 0)
            value = value | (ifr_pkg::CSR_DATA_W'($urandom) << keep_bits);
         csr_index <= ifr_pkg::CSR_IDX_W'(idx);
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(ifr_pkg::CSR_IDX_W'(idx), value);
         n_csr_writes++;
      end
      // writes to an undecoded index must change nothing
      if ($urandom_range(0, 3) == 0) begin
         value = ifr_pkg::CSR_DATA_W'($urandom);
         csr_index <= REG_SPARE;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(REG_SPARE, value);
         n_csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned n_directed;
      int unsigned phase_kind;
      int unsigned read_len;
      logic [ifr_pkg::CSR_DATA_W-1:0] big_dim;

      sb = new();
      reset         <= 1'b1;
      start         <= 1'b0;
      req_func      <= ifr_pkg::FUNC_WRITE;
      req_data_byte <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= ifr_pkg::REG_IMAGE_WIDTH;
      csr_data      <= '0;

      // values after reset
      reg_val[ifr_pkg::REG_IMAGE_WIDTH]  = ifr_pkg::CSR_DATA_W'(1);
      reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = ifr_pkg::CSR_DATA_W'(1);
      reg_val[ifr_pkg::REG_BYTES_PER_PX] = ifr_pkg::CSR_DATA_W'(1);
      reg_val[ifr_pkg::REG_MAX_LEVEL]    = ifr_pkg::CSR_DATA_W'(8'hff);
      reg_val[ifr_pkg::REG_MODE]         = ifr_pkg::CSR_DATA_W'(ifr_pkg::MODE_INVERT);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset settings: one single-byte pixel, inverted against 255
      send_read();                                 // nothing loaded yet, status set
      send_request(ifr_pkg::FUNC_WRITE, 8'h00);    // completes the one byte frame
      send_read();
      send_read();                                 // wraps onto the same byte
      send_request(ifr_pkg::FUNC_WRITE, 8'hff);    // write after load starts a new frame
      send_read();

      // 2 wide, 3 tall, rotated left: output is 3 wide, 2 tall
      wait_idle();
      reg_val[ifr_pkg::REG_IMAGE_WIDTH]  = ifr_pkg::CSR_DATA_W'(2);
      reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = ifr_pkg::CSR_DATA_W'(3);
      reg_val[ifr_pkg::REG_MODE]         = ifr_pkg::CSR_DATA_W'(ifr_pkg::MODE_ROT_LEFT);
      program_regs();
      for (int i = 0; i < 6; i++)
         send_request(ifr_pkg::FUNC_WRITE, ifr_pkg::BYTE_W'(1 << i));
      repeat (6) send_read();

      // same frame rotated right, no reload
      wait_idle();
      reg_val[ifr_pkg::REG_MODE] = ifr_pkg::CSR_DATA_W'(ifr_pkg::MODE_ROT_RIGHT);
      program_regs();
      repeat (6) send_read();

      // widest row and a vertical mirror: source address wraps onto byte 0
      wait_idle();
      reg_val[ifr_pkg::REG_IMAGE_WIDTH]  = ifr_pkg::CSR_DATA_W'(ifr_pkg::MAX_DIM);
      reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = ifr_pkg::CSR_DATA_W'(65);
      reg_val[ifr_pkg::REG_MODE]         = ifr_pkg::CSR_DATA_W'(ifr_pkg::MODE_VMIRROR);
      program_regs();
      send_read();
      n_directed = n_items;

      // --- random phases ---
      while (n_items < n_directed + RANDOM_ITEMS) begin
         phase_kind = $urandom_range(0, 9);
         n_phases++;
         wait_idle();
         if (phase_kind <= 6) begin
            // fresh small frame, then read it back, often past the wrap
            reg_val[ifr_pkg::REG_IMAGE_WIDTH]  = pick_small_dim();
            reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = pick_small_dim();
            reg_val[ifr_pkg::REG_BYTES_PER_PX] =
               ifr_pkg::CSR_DATA_W'($urandom_range(0, ifr_pkg::MAX_BPP));
            reg_val[ifr_pkg::REG_MAX_LEVEL]    = ifr_pkg::CSR_DATA_W'(pick_byte());
            reg_val[ifr_pkg::REG_MODE]         = pick_mode();
            program_regs();
            send_request(ifr_pkg::FUNC_WRITE, pick_byte());
            while (!sb.frame_ready) begin
               // an occasional read while the frame is still loading
               if ($urandom_range(0, 9) == 0)
                  send_read();
               else
                  send_request(ifr_pkg::FUNC_WRITE, pick_byte());
            end
            read_len = $urandom_range(1, 2 * sb.frame_size() + 2);
            repeat (read_len) begin
               // a stray write breaks off the read-back
               if ($urandom_range(0, 49) == 0)
                  send_request(ifr_pkg::FUNC_WRITE, pick_byte());
               else
                  send_read();
            end
         end else if (phase_kind <= 8) begin
            // change one register under a loaded frame: stale position,
            // clamped sizes, new transform on the same bytes
            case ($urandom_range(0, 4))
               0: reg_val[ifr_pkg::REG_IMAGE_WIDTH] = ($urandom_range(0, 3) == 0)
                     ? ifr_pkg::CSR_DATA_W'($urandom_range(ifr_pkg::MAX_DIM,
                                                           2**ifr_pkg::DIM_W - 1))
                     : pick_small_dim();
               1: reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = ($urandom_range(0, 3) == 0)
                     ? ifr_pkg::CSR_DATA_W'($urandom_range(ifr_pkg::MAX_DIM,
                                                           2**ifr_pkg::DIM_W - 1))
                     : pick_small_dim();
               2: reg_val[ifr_pkg::REG_BYTES_PER_PX] =
                     ifr_pkg::CSR_DATA_W'($urandom_range(0, ifr_pkg::MAX_BPP));
               3: reg_val[ifr_pkg::REG_MAX_LEVEL] = ifr_pkg::CSR_DATA_W'(pick_byte());
               default: reg_val[ifr_pkg::REG_MODE] = pick_mode();
            endcase
            program_regs();
            repeat ($urandom_range(1, 16)) send_read();
         end else begin
            // frame too big to finish, then shrink it to a frame of one or two
            // bytes, which the next write can complete
            big_dim = ifr_pkg::CSR_DATA_W'($urandom_range(ifr_pkg::MAX_DIM,
                                                          2**ifr_pkg::DIM_W - 1));
            if ($urandom_range(0, 1) == 0) begin
               reg_val[ifr_pkg::REG_IMAGE_WIDTH]  = big_dim;
               reg_val[ifr_pkg::REG_IMAGE_HEIGHT] =
                  ifr_pkg::CSR_DATA_W'($urandom_range(1, 2**ifr_pkg::DIM_W - 1));
            end else begin
               reg_val[ifr_pkg::REG_IMAGE_WIDTH]  =
                  ifr_pkg::CSR_DATA_W'($urandom_range(1, 2**ifr_pkg::DIM_W - 1));
               reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = big_dim;
            end
            reg_val[ifr_pkg::REG_BYTES_PER_PX] =
               ifr_pkg::CSR_DATA_W'($urandom_range(0, ifr_pkg::MAX_BPP));
            program_regs();
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 2) == 0)
                  send_read();
               else
                  send_request(ifr_pkg::FUNC_WRITE, pick_byte());
            end
            wait_idle();
            reg_val[ifr_pkg::REG_IMAGE_WIDTH]  = ifr_pkg::CSR_DATA_W'($urandom_range(1, 2));
            reg_val[ifr_pkg::REG_IMAGE_HEIGHT] = ifr_pkg::CSR_DATA_W'(1);
            reg_val[ifr_pkg::REG_BYTES_PER_PX] = ifr_pkg::CSR_DATA_W'(1);
            reg_val[ifr_pkg::REG_MODE]         = pick_mode();
            program_regs();
            send_request(ifr_pkg::FUNC_WRITE, pick_byte());
            repeat ($urandom_range(1, 8)) send_read();
         end
      end

      // --- drain and verdict ---
      start <= 1'b0;
      for (int i = 0; i < END_WAIT && sb.pending() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

      $display("%0d requests in %0d random phases, %0d register writes, %0d responses checked",
               n_items, n_phases, n_csr_writes, sb.n_checked);
      $display("%0d frames completed, %0d bytes read back, %0d read wraps, %0d early reads",
               sb.n_frames, sb.n_reads, sb.n_read_wraps, sb.n_early_reads);
      if (sb.n_errors == 0)
         $display("image_flip_rotate_invert_core test passed");
      else
         $display("image_flip_rotate_invert_core test failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/ifr_pkg.sv
design/ifr_csr.sv
design/ifr_mul.sv
design/ifr_store.sv
design/image_flip_rotate_invert_core.sv
test/tb.sv
